// ===== design/multilevel_queue_wait_stats_core_assert.svh =====
// assertion macros for the multilevel queue wait statistics core
`ifndef MULTILEVEL_QUEUE_WAIT_STATS_CORE_ASSERT_SVH
`define MULTILEVEL_QUEUE_WAIT_STATS_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// condition implies property in the same cycle
`define MLQ_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// condition implies property in the next cycle
`define MLQ_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MLQ_ASSERT_IMP(name, ante, cons)
`define MLQ_ASSERT_NXT(name, ante, cons)
`endif

`endif

// ===== design/mlq_pkg.sv =====
package mlq_pkg;

  localparam int LEVEL_DEPTH = 64;
  localparam int NUM_LEVELS  = 4;
  localparam int LVL_W       = 2;
  localparam int IDX_W       = $clog2(LEVEL_DEPTH);
  localparam int CNT_W       = $clog2(LEVEL_DEPTH + 1);
  localparam int ADDR_W      = LVL_W + IDX_W;
  localparam int MEM_DEPTH   = NUM_LEVELS * LEVEL_DEPTH;
  localparam int LEN_W       = 16;
  localparam int QUANT_W     = 16;
  localparam int SLICE_W     = 24;
  localparam int SUM_W       = LEN_W + CNT_W;
  localparam int WSUM_W      = SUM_W + CNT_W;
  localparam int NUM_W       = WSUM_W + 1;
  localparam int OUT_W       = 40;
  localparam int CFG_IDX_W   = 1;

  localparam logic [QUANT_W-1:0] QUANT_RESET = QUANT_W'(50);
  localparam logic [SLICE_W-1:0] SLICE_RESET = SLICE_W'(20 * 1000);

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE   = 1'b1;

  // level codes
  localparam logic [LVL_W-1:0] LVL_RR   = 2'd0;
  localparam logic [LVL_W-1:0] LVL_SJF1 = 2'd1;
  localparam logic [LVL_W-1:0] LVL_SJF2 = 2'd2;
  localparam logic [LVL_W-1:0] LVL_FIFO = 2'd3;

  typedef struct packed {
    logic [LEN_W-1:0] job_length;
    logic [LVL_W-1:0] level;
    logic             final_job;
  } job_t;

  typedef struct packed {
    logic [LVL_W-1:0] level_out;
    logic [OUT_W-1:0] wait_total;
    logic [OUT_W-1:0] avg_turnaround;
    logic             dropped_any;
    logic             run_end;
  } res_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [CNT_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== design/multilevel_queue_wait_stats_core.sv =====
// Multilevel queue scheduler with per-level wait statistics.
// Job channel (job_valid / job_stall / job): one job per transfer with its
// length, level and a final mark. Result channel (res_valid / res_stall /
// res): after the final job, four transfers follow, levels 0 to 3 in order;
// run_end is set on the level 3 transfer.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 is
// the round robin quantum, index 1 the per-level slice; write only when idle.
// A job that goes to the tail of its level passes the load and write states
// before the next transfer (only the load state when its level is full and
// it is dropped); on the sorted levels 1 and 2 it also passes a read and a
// compare state for each stored job it is compared with, since the insertion
// loop steps through the job store one slot at a time. The run after the final
// job serves head jobs in turn in the shared serve unit, level by level and
// pass by pass, then the serial divider gives each level's average turnaround.
// job_stall stays high all along. A stalled result holds in the output
// register and the sequencer waits on it.
// Reset clears all batch state and loads quantum 50 and slice 20000; the job
// store needs no clearing, slots are read only after they are written.
`include "multilevel_queue_wait_stats_core_assert.svh"

module multilevel_queue_wait_stats_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          job_valid,
  output logic                          job_stall,
  input  mlq_pkg::job_t                 job,
  output logic                          res_valid,
  input  logic                          res_stall,
  output mlq_pkg::res_t                 res,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mlq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mlq_pkg::SLICE_W-1:0]   cfg_data
);
  import mlq_pkg::*;

  logic [QUANT_W-1:0] quantum;
  logic [SLICE_W-1:0] slice;
  logic               res_push;
  res_t               res_data;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum <= QUANT_RESET;
      slice   <= SLICE_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_QUANTUM) begin
        quantum <= cfg_data[QUANT_W-1:0];
      end else if (cfg_index == CFG_SLICE) begin
        slice <= cfg_data;
      end
    end
  end

  mlq_sched u_sched (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_stall (job_stall),
    .job       (job),
    .quantum   (quantum),
    .slice     (slice),
    .res_push  (res_push),
    .res_full  (res_valid),
    .res_data  (res_data)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_push) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res <= res_data;
    end
  end

  // checks
  `MLQ_ASSERT_NXT(a_busy_after_job, job_valid && !job_stall, job_stall)
  `MLQ_ASSERT_IMP(a_end_on_last_level, res_valid && res.run_end, res.level_out == LVL_FIFO)
  `MLQ_ASSERT_NXT(a_quiet_after_end, res_valid && !res_stall && res.run_end, !res_valid)
  `MLQ_ASSERT_NXT(a_hold_while_stalled, res_valid && res_stall, res_valid && $stable(res))

endmodule

// ===== design/mlq_div.sv =====
module mlq_div (
  input  logic              clk,
  input  logic              rst,
  input  mlq_pkg::div_req_t req,
  output mlq_pkg::div_rsp_t rsp
);
  import mlq_pkg::*;

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [NUM_W-1:0]  dividend;
  logic [NUM_W-1:0]  quot;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W:0]    trial;
  logic              ge;

  // one restoring step: bring down a bit, subtract if it fits
  always_comb begin
    trial = {rem, dividend[NUM_W-1]};
    ge    = trial >= {1'b0, req.den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy     <= 1'b1;
        rem      <= '0;
        dividend <= req.num;
        quot     <= '0;
        step     <= '0;
      end else if (busy) begin
        rem      <= ge ? CNT_W'(trial - {1'b0, req.den}) : CNT_W'(trial);
        dividend <= {dividend[NUM_W-2:0], 1'b0};
        quot     <= {quot[NUM_W-2:0], ge};
        step     <= step + STEP_W'(1);
        if (step == STEP_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

// ===== design/mlq_sched.sv =====
module mlq_sched (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         job_valid,
  output logic                         job_stall,
  input  mlq_pkg::job_t                job,
  input  logic [mlq_pkg::QUANT_W-1:0]  quantum,
  input  logic [mlq_pkg::SLICE_W-1:0]  slice,
  output logic                         res_push,
  input  logic                         res_full,
  output mlq_pkg::res_t                res_data
);
  import mlq_pkg::*;

  typedef enum logic [14:0] {
    ST_IDLE       = 15'b000000000000001,
    ST_LOAD       = 15'b000000000000010,
    ST_INS_RD     = 15'b000000000000100,
    ST_INS_CMP    = 15'b000000000001000,
    ST_INS_WR     = 15'b000000000010000,
    ST_PASS_START = 15'b000000000100000,
    ST_L0_CHECK   = 15'b000000001000000,
    ST_L0_TURN    = 15'b000000010000000,
    ST_SERVE      = 15'b000000100000000,
    ST_LV_INIT    = 15'b000001000000000,
    ST_LV_CHECK   = 15'b000010000000000,
    ST_PASS_END   = 15'b000100000000000,
    ST_REP_DIV    = 15'b001000000000000,
    ST_REP_WAIT   = 15'b010000000000000,
    ST_REP_PUSH   = 15'b100000000000000
  } state_t;

  state_t state;

  // latched job
  logic [LEN_W-1:0] cur_len;
  logic             cur_final;
  logic [LVL_W-1:0] cur_lv;
  logic [IDX_W-1:0] pos;

  // per-level bookkeeping
  logic [CNT_W-1:0]  count [NUM_LEVELS];
  logic [CNT_W-1:0]  live  [NUM_LEVELS];
  logic [IDX_W-1:0]  head  [NUM_LEVELS];
  logic [SUM_W-1:0]  svc   [NUM_LEVELS];
  logic [SUM_W-1:0]  lsum  [NUM_LEVELS];
  logic [WSUM_W-1:0] wsum  [NUM_LEVELS];
  logic              ovf;
  logic              progress;

  // budgets
  logic [SLICE_W-1:0] budget;
  logic [SLICE_W-1:0] rbud;
  logic [SLICE_W-1:0] extra;
  logic [SLICE_W-1:0] tt;
  logic [NUM_W-1:0]   avg;

  // job store: {length, remaining} per slot
  logic [2*LEN_W-1:0] mem [MEM_DEPTH];
  logic [2*LEN_W-1:0] rd_data;
  logic [ADDR_W-1:0]  rd_addr;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [2*LEN_W-1:0] mem_wdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // shared serve unit
  logic [LEN_W-1:0]   s_rem;
  logic [LEN_W-1:0]   s_len;
  logic               s_partial;
  logic [LEN_W-1:0]   s_amount;
  logic [SUM_W-1:0]   s_svc;
  logic [SUM_W-1:0]   s_wait;
  logic [SLICE_W-1:0] s_tt_after;
  logic [IDX_W-1:0]   s_tail;

  mlq_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    s_rem      = rd_data[LEN_W-1:0];
    s_len      = rd_data[2*LEN_W-1:LEN_W];
    s_partial  = {{(SLICE_W-LEN_W){1'b0}}, s_rem} > tt;
    s_amount   = s_partial ? tt[LEN_W-1:0] : s_rem;
    s_svc      = svc[cur_lv] + SUM_W'(s_amount);
    s_wait     = s_svc - SUM_W'(s_len);
    s_tt_after = s_partial ? '0 : tt - SLICE_W'(s_rem);
    s_tail     = head[cur_lv] + live[cur_lv][IDX_W-1:0];
  end

  // memory control
  always_comb begin
    rd_addr   = {cur_lv, pos - IDX_W'(1)};
    mem_we    = 1'b0;
    mem_waddr = {cur_lv, pos};
    mem_wdata = {cur_len, cur_len};
    case (state)
      ST_INS_CMP: begin
        mem_we    = rd_data[2*LEN_W-1:LEN_W] > cur_len;
        mem_wdata = rd_data;
      end
      ST_INS_WR: begin
        mem_we = 1'b1;
      end
      ST_L0_TURN, ST_LV_CHECK: begin
        rd_addr = {cur_lv, head[cur_lv]};
      end
      ST_SERVE: begin
        mem_we    = s_partial;
        mem_waddr = (cur_lv == LVL_RR) ? {cur_lv, s_tail} : {cur_lv, head[cur_lv]};
        mem_wdata = {s_len, s_rem - s_amount};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  // divider request and result
  assign div_req.start = (state == ST_REP_DIV);
  assign div_req.num   = NUM_W'(wsum[cur_lv]) + NUM_W'(lsum[cur_lv]);
  assign div_req.den   = count[cur_lv];

  assign job_stall = (state != ST_IDLE);
  assign res_push  = (state == ST_REP_PUSH) && !res_full;

  always_comb begin
    res_data.level_out      = cur_lv;
    res_data.wait_total     = OUT_W'(wsum[cur_lv]);
    res_data.avg_turnaround = OUT_W'(avg);
    res_data.dropped_any    = ovf;
    res_data.run_end        = (cur_lv == LVL_FIFO);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      ovf      <= 1'b0;
      progress <= 1'b0;
      cur_lv   <= '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        count[i] <= '0;
        live[i]  <= '0;
        head[i]  <= '0;
        svc[i]   <= '0;
        lsum[i]  <= '0;
        wsum[i]  <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (job_valid) begin
            cur_len   <= job.job_length;
            cur_lv    <= job.level;
            cur_final <= job.final_job;
            state     <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          pos <= count[cur_lv][IDX_W-1:0];
          if (count[cur_lv] >= CNT_W'(LEVEL_DEPTH)) begin
            ovf   <= 1'b1;
            state <= cur_final ? ST_PASS_START : ST_IDLE;
          end else if ((cur_lv == LVL_SJF1 || cur_lv == LVL_SJF2) && count[cur_lv] != '0) begin
            state <= ST_INS_RD;
          end else begin
            state <= ST_INS_WR;
          end
        end
        ST_INS_RD: begin
          state <= ST_INS_CMP;
        end
        // shift a longer job up one slot, or stop here
        ST_INS_CMP: begin
          if (rd_data[2*LEN_W-1:LEN_W] > cur_len) begin
            pos   <= pos - IDX_W'(1);
            state <= (pos == IDX_W'(1)) ? ST_INS_WR : ST_INS_RD;
          end else begin
            state <= ST_INS_WR;
          end
        end
        ST_INS_WR: begin
          count[cur_lv] <= count[cur_lv] + CNT_W'(1);
          live[cur_lv]  <= live[cur_lv] + CNT_W'(1);
          lsum[cur_lv]  <= lsum[cur_lv] + SUM_W'(cur_len);
          state         <= cur_final ? ST_PASS_START : ST_IDLE;
        end
        ST_PASS_START: begin
          cur_lv <= LVL_RR;
          if (live[0] == '0 && live[1] == '0 && live[2] == '0 && live[3] == '0) begin
            state <= ST_REP_DIV;
          end else begin
            progress <= 1'b0;
            budget   <= slice;
            state    <= ST_L0_CHECK;
          end
        end
        // round robin level: start a series of turns
        ST_L0_CHECK: begin
          if (budget != '0 && quantum != '0 && live[0] != '0) begin
            rbud  <= budget;
            extra <= '0;
            state <= ST_L0_TURN;
          end else begin
            cur_lv <= LVL_SJF1;
            state  <= ST_LV_INIT;
          end
        end
        ST_L0_TURN: begin
          if (rbud >= SLICE_W'(quantum) && live[0] != '0) begin
            rbud  <= rbud - SLICE_W'(quantum);
            tt    <= SLICE_W'(quantum);
            state <= ST_SERVE;
          end else if (live[0] == '0) begin
            cur_lv <= LVL_SJF1;
            state  <= ST_LV_INIT;
          end else begin
            budget <= extra;
            state  <= ST_L0_CHECK;
          end
        end
        // serve the head job of the current level
        ST_SERVE: begin
          progress     <= 1'b1;
          svc[cur_lv]  <= s_svc;
          if (s_partial) begin
            if (cur_lv == LVL_RR) begin
              head[cur_lv] <= head[cur_lv] + IDX_W'(1);
            end
          end else begin
            head[cur_lv] <= head[cur_lv] + IDX_W'(1);
            live[cur_lv] <= live[cur_lv] - CNT_W'(1);
            wsum[cur_lv] <= wsum[cur_lv] + WSUM_W'(s_wait);
          end
          if (cur_lv == LVL_RR) begin
            extra <= extra + s_tt_after;
            state <= ST_L0_TURN;
          end else begin
            tt    <= s_tt_after;
            state <= ST_LV_CHECK;
          end
        end
        ST_LV_INIT: begin
          tt    <= slice;
          state <= ST_LV_CHECK;
        end
        ST_LV_CHECK: begin
          if (live[cur_lv] != '0 && tt != '0) begin
            state <= ST_SERVE;
          end else if (cur_lv == LVL_FIFO) begin
            state <= ST_PASS_END;
          end else begin
            cur_lv <= cur_lv + LVL_W'(1);
            state  <= ST_LV_INIT;
          end
        end
        ST_PASS_END: begin
          if (progress) begin
            state <= ST_PASS_START;
          end else begin
            cur_lv <= LVL_RR;
            state  <= ST_REP_DIV;
          end
        end
        ST_REP_DIV: begin
          state <= ST_REP_WAIT;
        end
        ST_REP_WAIT: begin
          if (div_rsp.done) begin
            avg   <= (count[cur_lv] == '0) ? '0 : div_rsp.quot;
            state <= ST_REP_PUSH;
          end
        end
        // hand one level's result to the output register
        ST_REP_PUSH: begin
          if (!res_full) begin
            if (cur_lv == LVL_FIFO) begin
              ovf    <= 1'b0;
              cur_lv <= '0;
              for (int i = 0; i < NUM_LEVELS; i++) begin
                count[i] <= '0;
                live[i]  <= '0;
                head[i]  <= '0;
                svc[i]   <= '0;
                lsum[i]  <= '0;
                wsum[i]  <= '0;
              end
              state <= ST_IDLE;
            end else begin
              cur_lv <= cur_lv + LVL_W'(1);
              state  <= ST_REP_DIV;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

import mlq_pkg::*;

// scheduling predictor plus expected result store
class mlq_scoreboard;
  longint unsigned quantum, slice;
  longint unsigned len_mem[NUM_LEVELS*LEVEL_DEPTH];
  longint unsigned rem_mem[NUM_LEVELS*LEVEL_DEPTH];
  longint unsigned wait_mem[NUM_LEVELS*LEVEL_DEPTH];
  int unsigned     cnt[NUM_LEVELS], head[NUM_LEVELS], live[NUM_LEVELS];
  longint unsigned len_total[NUM_LEVELS], wait_acc[NUM_LEVELS];
  bit              dropped;
  res_t            level_stats_q[$];
  int              errors;

  function new();
    quantum = QUANT_RESET;
    slice   = SLICE_RESET;
    errors  = 0;
    clear_batch();
  endfunction

  function void clear_batch();
    for (int l = 0; l < NUM_LEVELS; l++) begin
      cnt[l] = 0; head[l] = 0; live[l] = 0; len_total[l] = 0; wait_acc[l] = 0;
    end
    dropped = 0;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, longint unsigned val);
    if (idx == CFG_QUANTUM) quantum = val & 16'hFFFF;
    else slice = val & 24'hFFFFFF;
  endfunction

  function int unsigned pos(int unsigned l, int unsigned i);
    return l * LEVEL_DEPTH + (head[l] + i) % LEVEL_DEPTH;
  endfunction

  function void move_job(int unsigned dst, int unsigned src);
    len_mem[dst] = len_mem[src];
    rem_mem[dst] = rem_mem[src];
    wait_mem[dst] = wait_mem[src];
  endfunction

  function void add_job(longint unsigned len, int unsigned l);
    int unsigned n, p;
    n = cnt[l];
    p = n;
    if (n >= LEVEL_DEPTH) begin
      dropped = 1;
      return;
    end
    // shortest-first levels insert behind equal lengths
    if (l == LVL_SJF1 || l == LVL_SJF2) begin
      p = 0;
      while (p < n && len_mem[pos(l, p)] <= len) p++;
      for (int unsigned i = n; i > p; i--) move_job(pos(l, i), pos(l, i - 1));
    end
    len_mem[pos(l, p)] = len;
    rem_mem[pos(l, p)] = len;
    wait_mem[pos(l, p)] = 0;
    cnt[l] = n + 1;
    live[l] = n + 1;
    len_total[l] += len;
  endfunction

  function void charge_others(int unsigned l, longint unsigned amt);
    longint unsigned w;
    for (int unsigned i = 1; i < live[l]; i++) begin
      w = wait_mem[pos(l, i)] + amt;
      wait_mem[pos(l, i)] = (w > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : w;
    end
  endfunction

  // serve the head job of a level from the given budget
  function void serve_head(int unsigned l, ref longint unsigned budget);
    int unsigned s;
    longint unsigned r, w;
    s = pos(l, 0);
    r = rem_mem[s];
    if (r > budget) begin
      rem_mem[s] = r - budget;
      charge_others(l, budget);
      budget = 0;
      if (l == LVL_RR) begin
        move_job(pos(l, live[l]), s);
        head[l] = (head[l] + 1) % LEVEL_DEPTH;
      end
    end else begin
      budget -= r;
      charge_others(l, r);
      w = wait_acc[l] + wait_mem[s];
      wait_acc[l] = (w > 40'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : w;
      head[l] = (head[l] + 1) % LEVEL_DEPTH;
      live[l]--;
    end
  endfunction

  function bit rr_pass();
    bit moved;
    longint unsigned budget, turns, extra, tt;
    moved = 0;
    budget = slice;
    while (budget > 0 && quantum > 0 && live[LVL_RR] > 0) begin
      turns = budget / quantum;
      extra = 0;
      for (longint unsigned k = 0; k < turns && live[LVL_RR] > 0; k++) begin
        tt = quantum;
        serve_head(LVL_RR, tt);
        extra += tt;
        moved = 1;
      end
      if (live[LVL_RR] == 0) break;
      budget = extra;
    end
    return moved;
  endfunction

  function bit level_pass(int unsigned l);
    bit moved;
    longint unsigned tt;
    moved = 0;
    tt = slice;
    while (live[l] > 0 && tt > 0) begin
      serve_head(l, tt);
      moved = 1;
    end
    return moved;
  endfunction

  // accepted job transfer
  function void note_job(job_t j);
    bit p;
    longint unsigned avg;
    res_t r;
    add_job(j.job_length, j.level);
    if (!j.final_job) return;
    while (live[0] + live[1] + live[2] + live[3] != 0) begin
      p = rr_pass();
      p = level_pass(LVL_SJF1) || p;
      p = level_pass(LVL_SJF2) || p;
      p = level_pass(LVL_FIFO) || p;
      if (!p) break;
    end
    for (int l = 0; l < NUM_LEVELS; l++) begin
      avg = 0;
      if (cnt[l] != 0) begin
        avg = (wait_acc[l] + len_total[l]) / cnt[l];
        if (avg > 40'hFF_FFFF_FFFF) avg = 40'hFF_FFFF_FFFF;
      end
      r.level_out = LVL_W'(l);
      r.wait_total = OUT_W'(wait_acc[l]);
      r.avg_turnaround = OUT_W'(avg);
      r.dropped_any = dropped;
      r.run_end = (l == LVL_FIFO);
      level_stats_q = {level_stats_q, r};
    end
    clear_batch();
  endfunction

  task report(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // accepted result transfer
  task check_res(res_t r);
    res_t e;
    if (level_stats_q.size() == 0) begin
      report("unexpected result, level", r.level_out, 0);
      return;
    end
    e = level_stats_q.pop_front();
    if (r.level_out !== e.level_out) report("level_out", r.level_out, e.level_out);
    if (r.wait_total !== e.wait_total) report("wait_total", r.wait_total, e.wait_total);
    if (r.avg_turnaround !== e.avg_turnaround)
      report("avg_turnaround", r.avg_turnaround, e.avg_turnaround);
    if (r.dropped_any !== e.dropped_any) report("dropped_any", r.dropped_any, e.dropped_any);
    if (r.run_end !== e.run_end) report("run_end", r.run_end, e.run_end);
  endtask
endclass

module tb_top;
  localparam int IDLE_LIMIT = 4_000_000;
  localparam int SETTLE = 300;

  logic                 clk, rst;
  logic                 job_valid, job_stall;
  job_t                 job;
  logic                 res_valid, res_stall;
  res_t                 res;
  logic                 cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SLICE_W-1:0]   cfg_data;

  mlq_scoreboard sb;
  bit            idle_on;
  int            quiet_cycles;

  multilevel_queue_wait_stats_core u_top (
    .clk(clk), .rst(rst),
    .job_valid(job_valid), .job_stall(job_stall), .job(job),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // result sink, random stall and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && !res_stall) sb.check_res(res);
      if ((res_valid && !res_stall) || (job_valid && !job_stall) ||
          (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > IDLE_LIMIT) begin
        $display("FAIL multilevel_queue_wait_stats_core");
        $finish;
      end
    end
    res_stall <= idle_on && ($urandom_range(99) < 8);
  end

  task automatic send_job(int unsigned len, int unsigned lvl, bit fin);
    job_t j;
    j.job_length = LEN_W'(len);
    j.level = LVL_W'(lvl);
    j.final_job = fin;
    if (idle_on && $urandom_range(99) < 8) begin
      job_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    job_valid <= 1;
    job <= j;
    @(posedge clk);
    while (job_stall) @(posedge clk);
    sb.note_job(j);
  endtask

  // let every expected result arrive, then let the block settle
  task automatic drain();
    job_valid <= 0;
    while (sb.level_stats_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= SLICE_W'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    sb.set_reg(idx, val);
  endtask

  task automatic random_batches(int nbatch, int unsigned max_len);
    int n;
    for (int b = 0; b < nbatch; b++) begin
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++)
        send_job($urandom_range(max_len), $urandom_range(3), i == n - 1);
    end
  endtask

  task automatic new_setting(int unsigned q, int unsigned s);
    drain();
    write_reg(CFG_QUANTUM, q);
    write_reg(CFG_SLICE, s);
  endtask

  initial begin
    sb = new();
    idle_on = 1;
    rst = 1;
    job_valid = 0;
    job = '0;
    cfg_valid = 0;
    cfg_index = CFG_QUANTUM;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    rst <= 0;

    // directed: every level, length extremes, ties in the sorted levels
    send_job(0, LVL_RR, 0);
    send_job(65535, LVL_RR, 0);
    send_job(120, LVL_RR, 0);
    send_job(300, LVL_SJF1, 0);
    send_job(5, LVL_SJF1, 0);
    send_job(5, LVL_SJF1, 0);
    send_job(0, LVL_SJF1, 0);
    send_job(65535, LVL_SJF1, 0);
    send_job(40, LVL_SJF2, 0);
    send_job(7, LVL_SJF2, 0);
    send_job(65535, LVL_FIFO, 0);
    send_job(3, LVL_FIFO, 0);
    send_job(9, LVL_SJF2, 1);
    // lone final job, other levels empty
    send_job(0, LVL_FIFO, 1);
    // full level drops the extra job and a dropped final job
    for (int i = 0; i < LEVEL_DEPTH + 1; i++) send_job(2, LVL_FIFO, 0);
    send_job(4, LVL_FIFO, 1);

    random_batches(3, 2000);

    // smallest settings
    new_setting(1, 1);
    random_batches(2, 12);

    // largest settings, no idling on either side
    new_setting(65535, 16777215);
    idle_on = 0;
    random_batches(3, 65535);
    idle_on = 1;

    // slice below quantum: round robin level starves
    new_setting(50, 30);
    random_batches(2, 400);

    new_setting(7, 100);
    random_batches(3, 1000);

    drain();
    if (sb.errors == 0)
      $display("PASS multilevel_queue_wait_stats_core");
    else
      $display("FAIL multilevel_queue_wait_stats_core");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+design
design/mlq_pkg.sv
design/mlq_div.sv
design/mlq_sched.sv
design/multilevel_queue_wait_stats_core.sv
test/tb_top.sv
